>>> design/hslhr_pkg.sv
// hslhr_pkg: types, fixed point constants, register indexes and stage map
// for the hue replacement pipeline
// used by hslhr_to_hsl and hsl_hue_replace_pixel, no dependencies
package hslhr_pkg;

	typedef logic [15:0] hue_t;   // degrees, unsigned 9.7
	typedef logic [14:0] pct_t;   // percent, unsigned 7.8

	typedef struct packed {
		hue_t hue;
		pct_t sat;
		pct_t lum;
	} hsl_t;

	localparam hue_t HUE_FULL  = 16'd46080;
	localparam hue_t HUE_SIXTY = 16'd7680;
	localparam hue_t HUE_ONE   = 16'd128;
	localparam pct_t PCT_FULL  = 15'd25600;
	localparam pct_t PCT_HALF  = 15'd12800;

	// reciprocals, 2^31 / d rounded up (2^28 for the last one)
	localparam logic [63:0] RECIP_ONE = 64'd2147483648;
	localparam logic [31:0] RECIP_255 = 32'((RECIP_ONE + 64'd254) / 64'd255);
	localparam logic [31:0] RECIP_100 = 32'((RECIP_ONE + 64'd99) / 64'd100);
	localparam logic [18:0] RECIP_625 = 19'((64'd268435456 + 64'd624) / 64'd625);

	localparam int CFG_IDX_W = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ENABLE   = 3'd0,
		CFG_REF      = 3'd1,
		CFG_TARGET   = 3'd2,
		CFG_STRENGTH = 3'd3,
		CFG_WINDOW   = 3'd4,
		CFG_EXACT    = 3'd5
	} cfg_idx_t;

	typedef enum logic [1:0] {
		MODE_PASS,
		MODE_EXACT,
		MODE_BLEND,
		MODE_SHIFT
	} mode_t;

	typedef enum logic [2:0] {
		SEC_R_Y,
		SEC_Y_G,
		SEC_G_C,
		SEC_C_B,
		SEC_B_M,
		SEC_M_R
	} sector_t;

	typedef struct packed {
		logic        last;
		logic [23:0] rgb;
		pct_t        sat;
		pct_t        lum;
		mode_t       mode;
	} carry_t;

	// stage map
	localparam int LANE_LAT = 4;
	localparam int DIV_BITS = 15;
	localparam int ST_P1    = LANE_LAT + 1;
	localparam int ST_P2    = LANE_LAT + 2;
	localparam int ST_SEL   = ST_P2 + DIV_BITS + 1;
	localparam int ST_R1    = ST_SEL + 1;
	localparam int ST_R2    = ST_SEL + 2;
	localparam int ST_R3    = ST_SEL + 3;
	localparam int ST_R4    = ST_SEL + 4;
	localparam int NUM_ST   = ST_SEL + 5;

endpackage

>>> design/hslhr_to_hsl.sv
// hslhr_to_hsl: four stage rgb to hsl converter, hue 9.7, sat and lum 7.8
// divisions by reciprocal table lookup and one multiply
// depends on hslhr_pkg
module hslhr_to_hsl (
	input  logic              clk,
	input  logic              en,
	input  logic [7:0]        red,
	input  logic [7:0]        green,
	input  logic [7:0]        blue,
	output hslhr_pkg::hsl_t   hsl
);
	import hslhr_pkg::*;

	logic [31:0] recip [256];

	for (genvar d = 0; d < 256; d++) begin : g_recip
		if (d == 0) begin : g_zero
			assign recip[d] = '0;
		end else begin : g_val
			localparam logic [31:0] RV = 32'((RECIP_ONE + 64'(d) - 64'd1) / 64'(d));
			assign recip[d] = RV;
		end
	end

	// stage 1: max, min, sector base
	logic [7:0] mx, mn, adf, den;
	logic [8:0] sum;
	logic       neg;
	hue_t       base;

	always_comb begin
		mx = red;
		if (green > mx) mx = green;
		if (blue > mx) mx = blue;
		mn = red;
		if (green < mn) mn = green;
		if (blue < mn) mn = blue;
		sum = {1'b0, mx} + {1'b0, mn};
		den = (sum > 9'd255) ? 8'(9'd510 - sum) : sum[7:0];
		if (mx == red) begin
			base = '0;
			neg  = blue > green;
			adf  = neg ? blue - green : green - blue;
		end else if (mx == green) begin
			base = 16'(2 * HUE_SIXTY);
			neg  = red > blue;
			adf  = neg ? red - blue : blue - red;
		end else begin
			base = 16'(4 * HUE_SIXTY);
			neg  = green > red;
			adf  = neg ? green - red : red - green;
		end
	end

	logic [8:0] sum_s1;
	logic [7:0] dlt_s1, den_s1, adf_s1;
	logic       neg_s1;
	hue_t       base_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s1  <= sum;
			dlt_s1  <= mx - mn;
			den_s1  <= den;
			adf_s1  <= adf;
			neg_s1  <= neg;
			base_s1 <= base;
		end
	end

	// stage 2: numerators and reciprocals
	// negative hue offsets round toward minus infinity: add delta-1 first
	logic [22:0] ns_s2, nl_s2;
	logic [20:0] nh_s2;
	logic [31:0] rs_s2, rh_s2;
	logic        neg_s2, grey_s2;
	hue_t        base_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			ns_s2   <= 23'(dlt_s1) * 23'(PCT_FULL);
			nh_s2   <= 21'(adf_s1) * 21'(HUE_SIXTY)
				+ (neg_s1 ? 21'(dlt_s1 - 8'd1) : 21'd0);
			nl_s2   <= 23'(sum_s1) * 23'(PCT_HALF);
			rs_s2   <= recip[den_s1];
			rh_s2   <= recip[dlt_s1];
			neg_s2  <= neg_s1;
			grey_s2 <= dlt_s1 == 8'd0;
			base_s2 <= base_s1;
		end
	end

	// stage 3: reciprocal multiplies
	logic [54:0] ps, pl;
	logic [52:0] ph;

	assign ps = 55'(ns_s2) * 55'(rs_s2);
	assign pl = 55'(nl_s2) * 55'(RECIP_255);
	assign ph = 53'(nh_s2) * 53'(rh_s2);

	pct_t        qs_s3, ql_s3;
	logic [12:0] qh_s3;
	logic        neg_s3, grey_s3;
	hue_t        base_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			qs_s3   <= ps[45:31];
			ql_s3   <= pl[45:31];
			qh_s3   <= ph[43:31];
			neg_s3  <= neg_s2;
			grey_s3 <= grey_s2;
			base_s3 <= base_s2;
		end
	end

	// stage 4: hue assembly with wrap below zero
	hsl_t hsl_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			if (grey_s3)
				hsl_s4.hue <= '0;
			else if (!neg_s3)
				hsl_s4.hue <= base_s3 + 16'(qh_s3);
			else if (base_s3 == '0)
				hsl_s4.hue <= HUE_FULL - 16'(qh_s3);
			else
				hsl_s4.hue <= base_s3 - 16'(qh_s3);
			hsl_s4.sat <= grey_s3 ? '0 : qs_s3;
			hsl_s4.lum <= ql_s3;
		end
	end

	assign hsl = hsl_s4;

endmodule

>>> design/hsl_hue_replace_pixel.sv
// hsl_hue_replace_pixel: streaming per-pixel hue replacement in hsl space
// top level, uses hslhr_pkg and three hslhr_to_hsl converters
//
//   channel  | direction | handshake              | payload
//   s_*      | in        | s_tvalid / s_tready    | tdata blue,green,red; tlast
//   m_*      | out       | m_tvalid / m_tready    | tdata blue,green,red; tlast
//   cfg_*    | in        | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// one pixel per clock while the output word is not held by m_tready, 27 register
// stages, 15 of them in the restoring divider for the hue shift amount
// arst_n clears valid bits and resets config registers (target to white), payload registers are not reset
// a stall on m_tready freezes the whole pipeline; s_tready drops only while
// the output word is held, cfg_ready is always high
module hsl_hue_replace_pixel (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [23:0]                      s_tdata,   // blue, green, red (red lowest)
	input  logic                             s_tlast,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [23:0]                      m_tdata,   // blue, green, red (red lowest)
	output logic                             m_tlast,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [hslhr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [23:0]                      cfg_data
);
	import hslhr_pkg::*;

	// config registers
	logic        enable_q, exact_q;
	logic [23:0] ref_q, tgt_q;
	logic [6:0]  strength_q;
	logic [8:0]  window_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q   <= 1'b0;
			ref_q      <= '0;
			tgt_q      <= 24'hFFFFFF;
			strength_q <= '0;
			window_q   <= '0;
			exact_q    <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_idx_t'(cfg_index))
				CFG_ENABLE:   enable_q   <= cfg_data[0];
				CFG_REF:      ref_q      <= cfg_data;
				CFG_TARGET:   tgt_q      <= cfg_data;
				CFG_STRENGTH: strength_q <= cfg_data[6:0];
				CFG_WINDOW:   window_q   <= cfg_data[8:0];
				CFG_EXACT:    exact_q    <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// global advance: everything moves unless the output word is stuck
	logic              en;
	logic [NUM_ST:1]   vld_s;

	assign en       = ~vld_s[NUM_ST] | m_tready;
	assign s_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s <= '0;
		else if (en)
			vld_s <= {vld_s[NUM_ST-1:1], s_tvalid};
	end

	// hsl converters: pixel, reference and target run side by side so the
	// reference hues line up with each pixel
	hsl_t pix_hsl, ref_hsl, tgt_hsl;

	hslhr_to_hsl u_pix (
		.clk(clk), .en(en),
		.red(s_tdata[7:0]), .green(s_tdata[15:8]), .blue(s_tdata[23:16]),
		.hsl(pix_hsl)
	);

	hslhr_to_hsl u_ref (
		.clk(clk), .en(en),
		.red(ref_q[23:16]), .green(ref_q[15:8]), .blue(ref_q[7:0]),
		.hsl(ref_hsl)
	);

	hslhr_to_hsl u_tgt (
		.clk(clk), .en(en),
		.red(tgt_q[23:16]), .green(tgt_q[15:8]), .blue(tgt_q[7:0]),
		.hsl(tgt_hsl)
	);

	// p1: distance to reference, mode decision
	hue_t               ph, ch, th, dist5, y15, dh5;
	logic               lt5;
	logic [6:0]         st5;
	logic signed [17:0] goal5;
	mode_t              mode5;

	always_comb begin
		ph    = pix_hsl.hue;
		ch    = ref_hsl.hue;
		th    = tgt_hsl.hue;
		dist5 = (ph > ch) ? ph - ch : ch - ph;
		lt5   = ph < ch;
		// within one degree also lands on the 2 degree floor
		y15   = (dist5 < 16'd256) ? 16'd256 : dist5;
		st5   = (strength_q > 7'd100) ? 7'd100 : strength_q;
		dh5   = (th > ch) ? th - ch : ch - th;
		goal5 = lt5 ? $signed({2'b0, th}) + $signed({2'b0, dist5})
			: $signed({2'b0, th}) - $signed({2'b0, dist5});
		if (!enable_q)
			mode5 = MODE_PASS;
		else if (exact_q && dist5 < HUE_ONE)
			mode5 = MODE_EXACT;
		else if (dist5 < {window_q, 7'b0})
			mode5 = MODE_BLEND;
		else
			mode5 = MODE_SHIFT;
	end

	// side data shift line, sat, lum and mode join at p1
	carry_t side_s [1:NUM_ST];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 2; i <= NUM_ST; i++) begin
				if (i != ST_P1)
					side_s[i] <= side_s[i-1];
			end
			side_s[1].last     <= s_tlast;
			side_s[1].rgb      <= s_tdata;
			side_s[1].sat      <= '0;
			side_s[1].lum      <= '0;
			side_s[1].mode     <= MODE_PASS;
			side_s[ST_P1].last <= side_s[ST_P1-1].last;
			side_s[ST_P1].rgb  <= side_s[ST_P1-1].rgb;
			side_s[ST_P1].sat  <= pix_hsl.sat;
			side_s[ST_P1].lum  <= pix_hsl.lum;
			side_s[ST_P1].mode <= mode5;
		end
	end

	hue_t               ph_s5, th_s5, dh_s5, y1_s5;
	logic [6:0]         st_s5;
	logic signed [17:0] goal_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			ph_s5   <= ph;
			th_s5   <= th;
			dh_s5   <= dh5;
			y1_s5   <= y15;
			st_s5   <= st5;
			goal_s5 <= goal5;
		end
	end

	// p2: shift numerator and divisor, blend numerator offset by a full
	// turn times 100 so it stays positive
	logic [22:0]        dst6, t16;
	logic signed [25:0] t26, nbs6;

	always_comb begin
		dst6 = 23'(dh_s5) * 23'(st_s5);
		t16  = 23'(7'd100 - st_s5) * 23'(ph_s5);
		t26  = $signed({19'b0, st_s5}) * $signed({{8{goal_s5[17]}}, goal_s5});
		nbs6 = $signed({3'b0, t16}) + t26 + 26'sd4608000;
	end

	logic [29:0] nd_s6;
	logic [22:0] dd_s6;
	logic [23:0] nb_s6;
	hue_t        ph_s6, th_s6;

	always_ff @(posedge clk) begin
		if (en) begin
			nd_s6 <= {dst6, 7'b0};
			dd_s6 <= 23'(y1_s5) * 23'd100;
			nb_s6 <= nbs6[23:0];
			ph_s6 <= ph_s5;
			th_s6 <= th_s5;
		end
	end

	// restoring divider, one quotient bit per stage, msb first
	logic [29:0]         rem_s [DIV_BITS];
	logic [22:0]         dvs_s [DIV_BITS];
	logic [DIV_BITS-1:0] quo_s [DIV_BITS];
	hue_t                dph_s [DIV_BITS];
	hue_t                dth_s [DIV_BITS];
	logic [17:0]         qb_s  [DIV_BITS];

	logic [29:0]         rin_c [DIV_BITS];
	logic [22:0]         din_c [DIV_BITS];
	logic [DIV_BITS-1:0] qin_c [DIV_BITS];
	logic [37:0]         sh_c  [DIV_BITS];
	logic [DIV_BITS-1:0] bit_c [DIV_BITS];
	logic [55:0]         bprod;

	assign bprod = 56'(nb_s6) * 56'(RECIP_100);

	always_comb begin
		rin_c[0] = nd_s6;
		din_c[0] = dd_s6;
		qin_c[0] = '0;
		for (int k = 1; k < DIV_BITS; k++) begin
			rin_c[k] = rem_s[k-1];
			din_c[k] = dvs_s[k-1];
			qin_c[k] = quo_s[k-1];
		end
		for (int k = 0; k < DIV_BITS; k++) begin
			sh_c[k]  = 38'(din_c[k]) << (DIV_BITS - 1 - k);
			bit_c[k] = DIV_BITS'(1) << (DIV_BITS - 1 - k);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < DIV_BITS; k++) begin
				dvs_s[k] <= din_c[k];
				if ({8'b0, rin_c[k]} >= sh_c[k]) begin
					rem_s[k] <= rin_c[k] - sh_c[k][29:0];
					quo_s[k] <= qin_c[k] | bit_c[k];
				end else begin
					rem_s[k] <= rin_c[k];
					quo_s[k] <= qin_c[k];
				end
			end
			dph_s[0] <= ph_s6;
			dth_s[0] <= th_s6;
			qb_s[0]  <= bprod[48:31];
			for (int k = 1; k < DIV_BITS; k++) begin
				dph_s[k] <= dph_s[k-1];
				dth_s[k] <= dth_s[k-1];
				qb_s[k]  <= qb_s[k-1];
			end
		end
	end

	// new hue select, both wraps into one turn
	hue_t        nh_c, bw_c, sph, sth;
	logic [17:0] sqb;
	logic [14:0] amt;

	always_comb begin
		sph = dph_s[DIV_BITS-1];
		sth = dth_s[DIV_BITS-1];
		sqb = qb_s[DIV_BITS-1];
		amt = quo_s[DIV_BITS-1];
		if (sqb >= 18'd92160)
			bw_c = 16'(sqb - 18'd92160);
		else if (sqb >= 18'd46080)
			bw_c = 16'(sqb - 18'd46080);
		else
			bw_c = sqb[15:0];
		case (side_s[ST_SEL-1].mode)
			MODE_EXACT: nh_c = sth;
			MODE_BLEND: nh_c = bw_c;
			MODE_SHIFT: nh_c = (sph < 16'(amt)) ? sph + HUE_FULL - 16'(amt)
				: sph - 16'(amt);
			default:    nh_c = sph;
		endcase
	end

	hue_t nh_s22;

	always_ff @(posedge clk) begin
		if (en)
			nh_s22 <= nh_c;
	end

	// r1: chroma base, sector, ramp
	logic [13:0] a_c;
	sector_t     sec_c;
	hue_t        hm_c;
	pct_t        lum22;

	always_comb begin
		lum22 = side_s[ST_SEL].lum;
		a_c   = (lum22 > PCT_HALF) ? 14'(PCT_FULL - lum22) : lum22[13:0];
		if (nh_s22 < HUE_SIXTY)
			sec_c = SEC_R_Y;
		else if (nh_s22 < 16'(2 * HUE_SIXTY))
			sec_c = SEC_Y_G;
		else if (nh_s22 < 16'(3 * HUE_SIXTY))
			sec_c = SEC_G_C;
		else if (nh_s22 < 16'(4 * HUE_SIXTY))
			sec_c = SEC_C_B;
		else if (nh_s22 < 16'(5 * HUE_SIXTY))
			sec_c = SEC_B_M;
		else
			sec_c = SEC_M_R;
		if (nh_s22 >= 16'(4 * HUE_SIXTY))
			hm_c = nh_s22 - 16'(4 * HUE_SIXTY);
		else if (nh_s22 >= 16'(2 * HUE_SIXTY))
			hm_c = nh_s22 - 16'(2 * HUE_SIXTY);
		else
			hm_c = nh_s22;
	end

	logic [13:0] a_s23;
	sector_t     sec_s23;
	logic [12:0] bb_s23;

	always_ff @(posedge clk) begin
		if (en) begin
			a_s23   <= a_c;
			sec_s23 <= sec_c;
			bb_s23  <= (hm_c > HUE_SIXTY) ? 13'(16'(2 * HUE_SIXTY) - hm_c) : hm_c[12:0];
		end
	end

	// r2: chroma product and lightness term
	logic [28:0] p_s24;
	logic [29:0] lt_s24;
	sector_t     sec_s24;
	logic [12:0] bb_s24;

	always_ff @(posedge clk) begin
		if (en) begin
			p_s24   <= 29'(a_s23) * 29'(side_s[ST_R1].sat);
			lt_s24  <= 30'(side_s[ST_R1].lum) * 30'(PCT_FULL);
			sec_s24 <= sec_s23;
			bb_s24  <= bb_s23;
		end
	end

	// r3: full chroma, ramp chroma, offset m
	logic [41:0] cd_s25, xd_s25, md_s25;
	sector_t     sec_s25;

	always_ff @(posedge clk) begin
		if (en) begin
			cd_s25  <= 42'(p_s24) * 42'(HUE_SIXTY);
			xd_s25  <= 42'(p_s24) * 42'(bb_s24);
			md_s25  <= 42'(lt_s24 - 30'(p_s24)) * 42'd3840;
			sec_s25 <= sec_s24;
		end
	end

	// r4: per channel sum, times 17 over 2^28 (255/dd = 17/(625*2^28))
	logic [41:0] rc_c, gc_c, bc_c;
	logic [47:0] rv_c, gv_c, bv_c;

	always_comb begin
		case (sec_s25)
			SEC_R_Y: begin rc_c = cd_s25; gc_c = xd_s25; bc_c = '0;     end
			SEC_Y_G: begin rc_c = xd_s25; gc_c = cd_s25; bc_c = '0;     end
			SEC_G_C: begin rc_c = '0;     gc_c = cd_s25; bc_c = xd_s25; end
			SEC_C_B: begin rc_c = '0;     gc_c = xd_s25; bc_c = cd_s25; end
			SEC_B_M: begin rc_c = xd_s25; gc_c = '0;     bc_c = cd_s25; end
			default: begin rc_c = cd_s25; gc_c = '0;     bc_c = xd_s25; end
		endcase
		rv_c = (48'(rc_c) + 48'(md_s25)) * 48'd17;
		gv_c = (48'(gc_c) + 48'(md_s25)) * 48'd17;
		bv_c = (48'(bc_c) + 48'(md_s25)) * 48'd17;
	end

	logic [18:0] tr_s26, tg_s26, tb_s26;

	always_ff @(posedge clk) begin
		if (en) begin
			tr_s26 <= rv_c[46:28];
			tg_s26 <= gv_c[46:28];
			tb_s26 <= bv_c[46:28];
		end
	end

	// r5: divide by 625, clamp, pass-through mux, output register
	logic [37:0] qr_c, qg_c, qb_c;
	logic [7:0]  or_c, og_c, ob_c;

	always_comb begin
		qr_c = 38'(tr_s26) * 38'(RECIP_625);
		qg_c = 38'(tg_s26) * 38'(RECIP_625);
		qb_c = 38'(tb_s26) * 38'(RECIP_625);
		or_c = (qr_c[37:28] > 10'd255) ? 8'd255 : qr_c[35:28];
		og_c = (qg_c[37:28] > 10'd255) ? 8'd255 : qg_c[35:28];
		ob_c = (qb_c[37:28] > 10'd255) ? 8'd255 : qb_c[35:28];
	end

	logic [23:0] out_s27;

	always_ff @(posedge clk) begin
		if (en) begin
			if (side_s[ST_R4].mode == MODE_PASS)
				out_s27 <= side_s[ST_R4].rgb;
			else
				out_s27 <= {ob_c, og_c, or_c};
		end
	end

	assign m_tvalid = vld_s[NUM_ST];
	assign m_tdata  = out_s27;
	assign m_tlast  = side_s[NUM_ST].last;

	// checks
	a_pix_hue_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[LANE_LAT] |-> pix_hsl.hue < HUE_FULL)
		else $error("pixel hue out of range");

	a_exact_needs_reg: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s[ST_P1] && side_s[ST_P1].mode == MODE_EXACT) |-> (exact_q && enable_q))
		else $error("exact mode without exact_replace");

	a_new_hue_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[ST_SEL] |-> nh_s22 < HUE_FULL)
		else $error("new hue not wrapped");

	a_pass_matches_enable: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[NUM_ST] |-> ((side_s[NUM_ST].mode == MODE_PASS) == !enable_q))
		else $error("pass mode disagrees with enable");

endmodule

>>> tb/hsl_hue_replace_pixel_tb.sv
// hsl_hue_replace_pixel_tb: self-checking bench for the streaming hue replacement block
// predicts every output word in fixed point hsl and checks it field by field
// depends on hslhr_pkg and hsl_hue_replace_pixel
module hsl_hue_replace_pixel_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import hslhr_pkg::*;

	localparam int HFULL = 46080;
	localparam int HSIX  = 7680;
	localparam int LAT   = 27;
	localparam longint CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       last;
	} pixel_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [23:0] s_tdata;   // blue, green, red (red lowest)
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;   // blue, green, red (red lowest)
	logic        m_tlast;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [23:0] cfg_data;

	hsl_hue_replace_pixel uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// shadow copy of the register file
	logic        sh_enable;
	logic [23:0] sh_ref;
	logic [23:0] sh_target;
	logic [6:0]  sh_strength;
	logic [8:0]  sh_window;
	logic        sh_exact;

	pixel_t pending_pixels[$];
	pixel_t recolored_expect[$];
	int     errors;
	longint cycles;
	bit     hold_src;      // sender holds off while set
	bit     burst_off;     // no random idling in the closing part
	int     long_stall;    // receiver hold-off, in cycles
	int     src_gap, snk_gap;
	bit     in_taken;      // input word accepted at the last rising edge

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	function automatic longint fdiv(longint n, longint d);
		longint q;
		q = n / d;
		if ((n % d) != 0 && n < 0) q--;
		return q;
	endfunction

	function automatic int hue_wrap(longint h);
		longint r;
		r = h % HFULL;
		if (r < 0) r += HFULL;
		return int'(r);
	endfunction

	function automatic void rgb_to_hsl(input int r, input int g, input int b,
			output int h, output int s, output int l);
		int mx, mn, sum, delta, den;
		longint base, diff;
		mx = r; mn = r;
		if (g > mx) mx = g;
		if (b > mx) mx = b;
		if (g < mn) mn = g;
		if (b < mn) mn = b;
		sum = mx + mn;
		l = sum * 12800 / 255;
		delta = mx - mn;
		h = 0; s = 0;
		if (delta != 0) begin
			den = 255 - (sum > 255 ? sum - 255 : 255 - sum);
			s = 25600 * delta / den;
			if (mx == r) begin
				base = 0; diff = g - b;
			end else if (mx == g) begin
				base = 2 * HSIX; diff = b - r;
			end else begin
				base = 4 * HSIX; diff = r - g;
			end
			h = hue_wrap(base + fdiv(HSIX * diff, delta));
		end
	endfunction

	function automatic logic [7:0] chan_out(longint comp, longint m);
		longint v;
		v = fdiv((comp + m) * 255, longint'(12800) * 25600 * 7680);
		if (v < 0) v = 0;
		if (v > 255) v = 255;
		return v[7:0];
	endfunction

	function automatic void hsl_to_rgb(input int h, input int s, input int l,
			inout pixel_t px);
		longint a, hm, bb, cd, xd, md, rc, gc, bc;
		a = 12800 - (l > 12800 ? l - 12800 : 12800 - l);
		hm = h % (2 * HSIX);
		bb = HSIX - (hm > HSIX ? hm - HSIX : HSIX - hm);
		cd = a * s * 7680;
		xd = a * s * bb;
		md = longint'(l) * 12800 * 7680 - cd / 2;
		case (h / HSIX)
			0: begin rc = cd; gc = xd; bc = 0; end
			1: begin rc = xd; gc = cd; bc = 0; end
			2: begin rc = 0; gc = cd; bc = xd; end
			3: begin rc = 0; gc = xd; bc = cd; end
			4: begin rc = xd; gc = 0; bc = cd; end
			default: begin rc = cd; gc = 0; bc = xd; end
		endcase
		px.red = chan_out(rc, md);
		px.green = chan_out(gc, md);
		px.blue = chan_out(bc, md);
	endfunction

	function automatic pixel_t recolor(pixel_t px);
		pixel_t o;
		int ph, ps, pl, ch, cs, cl, th, ts, tl, hdist, y1, newh;
		longint st, goal, num, diffh, amt;
		o = px;
		if (!sh_enable) return o;
		rgb_to_hsl(int'(px.red), int'(px.green), int'(px.blue), ph, ps, pl);
		rgb_to_hsl(int'(sh_ref[23:16]), int'(sh_ref[15:8]), int'(sh_ref[7:0]),
			ch, cs, cl);
		rgb_to_hsl(int'(sh_target[23:16]), int'(sh_target[15:8]),
			int'(sh_target[7:0]), th, ts, tl);
		st = sh_strength > 100 ? 100 : sh_strength;
		hdist = ph > ch ? ph - ch : ch - ph;
		y1 = hdist;
		if (hdist < 128) begin
			if (sh_exact) begin
				hsl_to_rgb(th, ps, pl, o);
				return o;
			end
			y1 = 256;
		end
		if (y1 < 256) y1 = 256;
		if (hdist < int'(sh_window) * 128) begin
			goal = (ph < ch) ? longint'(th) + hdist : longint'(th) - hdist;
			num = (100 - st) * ph + st * goal;
			newh = hue_wrap(fdiv(num, 100));
		end else begin
			diffh = th > ch ? th - ch : ch - th;
			amt = diffh * st * 128 / (100 * longint'(y1));
			newh = hue_wrap(ph - amt);
		end
		hsl_to_rgb(newh, ps, pl, o);
		return o;
	endfunction

	// input acceptance seen at the rising edge itself
	always @(posedge clk) begin
		in_taken <= arst_n && s_tvalid && s_tready;
	end

	// driver: offers the head of the pending queue, predicts on acceptance
	always @(negedge clk) begin
		if (arst_n) begin
			if (in_taken) begin
				recolored_expect.push_back(recolor(pending_pixels.pop_front()));
			end
			if (src_gap > 0) src_gap <= src_gap - 1;
			if (!s_tvalid || in_taken) begin
				if (pending_pixels.size() > 0 && !hold_src && src_gap == 0
						&& (burst_off || $urandom_range(0, 15) != 0)) begin
					s_tvalid <= 1'b1;
					s_tdata  <= {pending_pixels[0].blue, pending_pixels[0].green,
						pending_pixels[0].red};
					s_tlast  <= pending_pixels[0].last;
				end else begin
					s_tvalid <= 1'b0;
					if (!burst_off && src_gap == 0 && $urandom_range(0, 7) == 0)
						src_gap <= $urandom_range(1, 19);
				end
			end
		end
	end

	// receiver ready, with random bursts of idling and a long hold-off
	always @(negedge clk) begin
		if (arst_n) begin
			if (long_stall > 0) begin
				long_stall <= long_stall - 1;
				m_tready <= 1'b0;
			end else if (snk_gap > 0) begin
				snk_gap <= snk_gap - 1;
				m_tready <= 1'b0;
			end else if (!burst_off && $urandom_range(0, 9) == 0) begin
				snk_gap <= $urandom_range(1, 19);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// monitor: compares each output word with the oldest prediction
	always @(posedge clk) begin
		pixel_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (recolored_expect.size() == 0) begin
				$error("output word with nothing expected: %h", m_tdata);
				errors++;
			end else begin
				want = recolored_expect.pop_front();
				if (m_tdata[7:0] !== want.red) begin
					$error("out_red expected %0d got %0d", want.red, m_tdata[7:0]);
					errors++;
				end
				if (m_tdata[15:8] !== want.green) begin
					$error("out_green expected %0d got %0d", want.green, m_tdata[15:8]);
					errors++;
				end
				if (m_tdata[23:16] !== want.blue) begin
					$error("out_blue expected %0d got %0d", want.blue, m_tdata[23:16]);
					errors++;
				end
				if (m_tlast !== want.last) begin
					$error("out_last expected %0d got %0d", want.last, m_tlast);
					errors++;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	task automatic wait_drained();
		while (pending_pixels.size() > 0 || s_tvalid || recolored_expect.size() > 0)
			@(posedge clk);
		repeat (LAT + 4) @(posedge clk);
	endtask

	task automatic cfg_write(input cfg_idx_t idx, input logic [23:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			CFG_ENABLE:   sh_enable   = val[0];
			CFG_REF:      sh_ref      = val;
			CFG_TARGET:   sh_target   = val;
			CFG_STRENGTH: sh_strength = val[6:0];
			CFG_WINDOW:   sh_window   = val[8:0];
			CFG_EXACT:    sh_exact    = val[0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic push_pixel(input logic [23:0] rgb, input logic last);
		pixel_t p;
		p.red = rgb[23:16];
		p.green = rgb[15:8];
		p.blue = rgb[7:0];
		p.last = last;
		pending_pixels.push_back(p);
	endtask

	// random pixel, often near the reference hue so blend and exact paths get hit
	task automatic push_random(input int n);
		logic [23:0] c;
		for (int i = 0; i < n; i++) begin
			c = 24'($urandom());
			if ($urandom_range(0, 3) == 0) c = sh_ref ^ (24'($urandom()) & 24'h030303);
			if ($urandom_range(0, 15) == 0) c = {3{c[7:0]}};
			push_pixel(c, $urandom_range(0, 7) == 0);
		end
	endtask

	task automatic random_config();
		cfg_write(CFG_ENABLE, 24'($urandom_range(0, 5) != 0));
		cfg_write(CFG_REF, 24'($urandom()));
		cfg_write(CFG_TARGET, 24'($urandom()));
		cfg_write(CFG_STRENGTH, 24'($urandom_range(0, 127)));
		cfg_write(CFG_WINDOW, 24'($urandom_range(0, 511)));
		cfg_write(CFG_EXACT, 24'($urandom_range(0, 1)));
	endtask

	initial begin
		errors = 0; cycles = 0;
		hold_src = 0; burst_off = 0; long_stall = 0; src_gap = 0; snk_gap = 0;
		arst_n = 0;
		s_tvalid = 0; s_tdata = '0; s_tlast = 0;
		m_tready = 0;
		cfg_valid = 0; cfg_index = CFG_ENABLE; cfg_data = '0;
		sh_enable = 0; sh_ref = '0; sh_target = 24'hFFFFFF;
		sh_strength = '0; sh_window = '0; sh_exact = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// after reset the block passes pixels through unchanged
		push_pixel(24'h000000, 1'b0);
		push_pixel(24'hFFFFFF, 1'b1);
		push_pixel(24'h123456, 1'b0);
		wait_drained();

		// exact mode, pixel at the reference hue and one just off it
		cfg_write(CFG_ENABLE, 24'd1);
		cfg_write(CFG_REF, 24'hFF0000);
		cfg_write(CFG_TARGET, 24'h00FF00);
		cfg_write(CFG_STRENGTH, 24'd100);
		cfg_write(CFG_WINDOW, 24'd30);
		cfg_write(CFG_EXACT, 24'd1);
		push_pixel(24'hFF0000, 1'b0);
		push_pixel(24'h800000, 1'b0);
		push_pixel(24'hFF0100, 1'b0);
		push_pixel(24'h808080, 1'b0);       // grey stays grey
		push_pixel(24'hFF1000, 1'b0);       // inside the window
		push_pixel(24'hFF00F0, 1'b0);       // outside the window, shifted
		push_pixel(24'h0000FF, 1'b1);       // far, shifted
		wait_drained();

		// near the reference without exact mode, strength and window saturate
		cfg_write(CFG_EXACT, 24'd0);
		cfg_write(CFG_STRENGTH, 24'd127);
		cfg_write(CFG_WINDOW, 24'd511);
		push_pixel(24'hFF0000, 1'b0);
		push_pixel(24'hFF0100, 1'b0);
		push_pixel(24'h00FFFF, 1'b0);
		push_pixel(24'hFFFFFF, 1'b0);
		push_pixel(24'h010203, 1'b1);
		wait_drained();
		cfg_write(CFG_WINDOW, 24'd0);
		cfg_write(CFG_STRENGTH, 24'd0);
		push_pixel(24'hFF0100, 1'b0);
		push_pixel(24'h00FF00, 1'b0);
		wait_drained();
		cfg_write(CFG_STRENGTH, 24'd100);
		push_pixel(24'hFF0100, 1'b0);
		push_pixel(24'h7F3FC0, 1'b0);
		push_pixel(24'hAA55FF, 1'b1);
		wait_drained();

		// long receiver hold-off while the sender keeps offering
		push_random(60);
		@(negedge clk);
		long_stall = 300;
		wait_drained();

		// random phases, each under a fresh register setting
		for (int ph = 0; ph < 6; ph++) begin
			random_config();
			push_random(50);
			wait_drained();
		end

		// sender pauses until everything came back, then resumes
		random_config();
		hold_src = 1;
		push_random(20);
		hold_src = 0;
		while (pending_pixels.size() > 0) @(posedge clk);
		hold_src = 1;
		while (recolored_expect.size() > 0 || s_tvalid) @(posedge clk);
		hold_src = 0;
		push_random(20);
		wait_drained();

		// closing part at full rate
		burst_off = 1;
		random_config();
		push_random(40);
		wait_drained();

		if (errors == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

>>> sim.f
design/hslhr_pkg.sv
design/hslhr_to_hsl.sv
design/hsl_hue_replace_pixel.sv
tb/hsl_hue_replace_pixel_tb.sv
